// ===== sv/pulse_duty_frequency_meter_defines.svh =====
// Assertion macros shared by the pulse duty and frequency meter RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef PULSE_DUTY_FREQUENCY_METER_DEFINES_SVH
`define PULSE_DUTY_FREQUENCY_METER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define PDFM_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that, when true, implies another in the same cycle.
`define PDFM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A condition that, when true, implies another in the next cycle.
`define PDFM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/pdfm_pkg.sv =====
// Package for the pulse duty and frequency meter: field widths, constants
// and the command and status structs between controller and datapath.
`default_nettype none

package pdfm_pkg;

  localparam int RATE_W  = 25;
  localparam int FIELD_W = 16;
  localparam int DUTY_W  = 7;

  localparam logic [RATE_W-1:0] RATE_RESET = 25'd1000000;
  localparam logic [DUTY_W-1:0] DUTY_SCALE = 7'd100;

  // Commands issued by the controller to the datapath.
  typedef struct packed {
    logic advance;       // Request taken: sample pin, step the tick counter.
    logic cap_rise;      // Capture the counter at the opening rising edge.
    logic cap_fall;      // Capture the counter at the falling edge.
    logic cap_end;       // Closing rising edge: form high time, period, range.
    logic div_start;     // Launch the shared divider.
    logic div_sel_freq;  // Divider operands: 1 frequency, 0 duty.
    logic save_duty;     // Keep the quotient as duty.
    logic save_freq;     // Keep the quotient as frequency.
    logic load_out;      // Move the finished result into the output register.
  } pdfm_cmd_t;

  // Status returned by the datapath.
  typedef struct packed {
    logic rising;
    logic falling;
    logic span_ok;       // Captures strictly increase, using the current count.
    logic range_ok;      // Registered span check of the pending measurement.
    logic div_done;
  } pdfm_sts_t;

endpackage

`default_nettype wire

// ===== sv/pdfm_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Stand-alone; used by the meter datapath for duty and frequency.
`default_nettype none

module pdfm_div #(
  parameter int DIVIDEND_W = 25,
  parameter int DIVISOR_W  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic [DIVIDEND_W-1:0]      quotient,
  output logic                       done
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W:0]   trial;
  logic                 fits;

  assign trial = {rem, quotient[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The quotient register doubles as the dividend shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      quotient <= {quotient[DIVIDEND_W-2:0], fits};
      if (fits) begin
        rem <= DIVISOR_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[DIVISOR_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/pdfm_dp.sv =====
// Datapath of the meter: tick counter, edge detect, captures, divider
// operands and result registers. Uses pdfm_pkg and pdfm_div.
`default_nettype none

module pdfm_dp
  import pdfm_pkg::*;
#(
  parameter int COUNT_BITS = 16,
  parameter int DIV_W      = 25
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pdfm_cmd_t          cmd,
  output pdfm_sts_t               sts,
  input  wire logic               pin_level,
  input  wire logic               cfg_we,
  input  wire logic [RATE_W-1:0]  cfg_wdata,
  output logic                    in_range,
  output logic [FIELD_W-1:0]      high_ticks,
  output logic [FIELD_W-1:0]      period_ticks,
  output logic [DUTY_W-1:0]       duty_percent,
  output logic [RATE_W-1:0]       frequency_hz
);

  localparam int PROD_W = COUNT_BITS + DUTY_W;

  logic [COUNT_BITS-1:0] tick_count;
  logic                  last_level;
  logic [RATE_W-1:0]     tick_rate;
  logic [COUNT_BITS-1:0] rise_time;
  logic [COUNT_BITS-1:0] fall_time;
  logic [COUNT_BITS-1:0] high_r;
  logic [COUNT_BITS-1:0] period_r;
  logic                  range_r;
  logic [DUTY_W-1:0]     duty_r;
  logic [RATE_W-1:0]     freq_r;
  logic [PROD_W-1:0]     high_scaled;
  logic [DIV_W-1:0]      div_dividend;
  logic [DIV_W-1:0]      div_quot;
  logic                  div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      last_level <= 1'b1;
      tick_rate  <= RATE_RESET;
    end else begin
      if (cmd.advance) begin
        tick_count <= tick_count + COUNT_BITS'(1);
        last_level <= pin_level;
      end
      if (cfg_we) begin
        tick_rate <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_rise) begin
      rise_time <= tick_count;
    end
    if (cmd.cap_fall) begin
      fall_time <= tick_count;
    end
    if (cmd.cap_end) begin
      high_r   <= fall_time - rise_time;
      period_r <= tick_count - rise_time;
      range_r  <= sts.span_ok;
    end
    if (cmd.save_duty) begin
      duty_r <= div_quot[DUTY_W-1:0];
    end
    if (cmd.save_freq) begin
      freq_r <= div_quot[RATE_W-1:0];
    end
  end

  // A failed span check forces every field of the result to zero.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      in_range     <= range_r;
      high_ticks   <= range_r ? FIELD_W'(high_r) : '0;
      period_ticks <= range_r ? FIELD_W'(period_r) : '0;
      duty_percent <= range_r ? duty_r : '0;
      frequency_hz <= range_r ? freq_r : '0;
    end
  end

  assign high_scaled  = PROD_W'(high_r) * PROD_W'(DUTY_SCALE);
  assign div_dividend = cmd.div_sel_freq ? DIV_W'(tick_rate) : DIV_W'(high_scaled);

  pdfm_div #(
    .DIVIDEND_W(DIV_W),
    .DIVISOR_W (COUNT_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(div_dividend),
    .divisor (period_r),
    .quotient(div_quot),
    .done    (div_done)
  );

  always_comb begin
    sts.rising   = !last_level && pin_level;
    sts.falling  = last_level && !pin_level;
    sts.span_ok  = (rise_time < fall_time) && (fall_time < tick_count);
    sts.range_ok = range_r;
    sts.div_done = div_done;
  end

endmodule

`default_nettype wire

// ===== sv/pdfm_ctrl.sv =====
// Controller of the meter: edge sequencing, divider sequencing and the
// output handshake. Uses pdfm_pkg; drives the datapath by pdfm_cmd_t.
`default_nettype none

module pdfm_ctrl
  import pdfm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire pdfm_sts_t sts,
  output pdfm_cmd_t      cmd
);

  localparam logic [2:0] S_WAIT_RISE  = 3'd0;
  localparam logic [2:0] S_WAIT_FALL  = 3'd1;
  localparam logic [2:0] S_WAIT_RISE2 = 3'd2;
  localparam logic [2:0] S_DSTART     = 3'd3;
  localparam logic [2:0] S_DUTY       = 3'd4;
  localparam logic [2:0] S_FSTART     = 3'd5;
  localparam logic [2:0] S_FREQ       = 3'd6;
  localparam logic [2:0] S_LOAD       = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;
  logic       take;
  logic       out_free;

  assign in_ready = (state == S_WAIT_RISE) || (state == S_WAIT_FALL) ||
                    (state == S_WAIT_RISE2);
  assign take     = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    cmd.advance    = take;
    unique case (state)
      S_WAIT_RISE: begin
        if (take && sts.rising) begin
          cmd.cap_rise = 1'b1;
          state_next   = S_WAIT_FALL;
        end
      end
      S_WAIT_FALL: begin
        if (take && sts.falling) begin
          cmd.cap_fall = 1'b1;
          state_next   = S_WAIT_RISE2;
        end
      end
      S_WAIT_RISE2: begin
        if (take && sts.rising) begin
          cmd.cap_end = 1'b1;
          state_next  = sts.span_ok ? S_DSTART : S_LOAD;
        end
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_DUTY;
      end
      S_DUTY: begin
        if (sts.div_done) begin
          cmd.save_duty = 1'b1;
          state_next    = S_FSTART;
        end
      end
      S_FSTART: begin
        cmd.div_start    = 1'b1;
        cmd.div_sel_freq = 1'b1;
        state_next       = S_FREQ;
      end
      S_FREQ: begin
        cmd.div_sel_freq = 1'b1;
        if (sts.div_done) begin
          cmd.save_freq = 1'b1;
          state_next    = S_LOAD;
        end
      end
      S_LOAD: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_WAIT_RISE;
        end
      end
      default: begin
        state_next = S_WAIT_RISE;
      end
    endcase
  end

  // The output register stays full until taken; a load only happens when free.
  assign out_valid_next = cmd.load_out ? 1'b1 : (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_WAIT_RISE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pulse_duty_frequency_meter.sv =====
// Pulse duty and frequency meter. Each request is one sampled pin level per
// tick of a free-running COUNT_BITS counter; the block captures the count at a
// rising edge, the following falling edge and the next rising edge, then
// returns high time, period, duty (floor of 100*high/period) and frequency
// (tick_rate_hz/period). Between edges a request is taken every cycle. After
// the closing rising edge the block takes no request while one shared radix-2
// divider, W = max(COUNT_BITS+7, 25) bits wide, produces duty and then
// frequency, one bit per cycle. A measurement whose captures do not strictly
// increase (counter wrap) returns in_range low with all fields zero. A
// finished result waits in the output register while the next measurement
// proceeds; if the next one closes before that result is taken, requests stay
// blocked until it is.
// Depends on pdfm_pkg, pdfm_ctrl, pdfm_dp, pdfm_div and the defines header.
`default_nettype none

`include "pulse_duty_frequency_meter_defines.svh"

module pulse_duty_frequency_meter
  import pdfm_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [RATE_W-1:0] cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              pin_level,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   in_range,
  output logic [FIELD_W-1:0]     high_ticks,
  output logic [FIELD_W-1:0]     period_ticks,
  output logic [DUTY_W-1:0]      duty_percent,
  output logic [RATE_W-1:0]      frequency_hz
);

  localparam int DIV_W = (COUNT_BITS + DUTY_W > RATE_W) ? COUNT_BITS + DUTY_W : RATE_W;

  pdfm_cmd_t cmd;
  pdfm_sts_t sts;

  pdfm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pdfm_dp #(
    .COUNT_BITS(COUNT_BITS),
    .DIV_W     (DIV_W)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .pin_level   (pin_level),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_range    (in_range),
    .high_ticks  (high_ticks),
    .period_ticks(period_ticks),
    .duty_percent(duty_percent),
    .frequency_hz(frequency_hz)
  );

  `PDFM_ASSERT_SAME(a_div_blocks_input, clk, rst, cmd.div_start || sts.div_done, !in_ready, "divider active while requests are taken")
  `PDFM_ASSERT_SAME(a_div_only_in_range, clk, rst, cmd.div_start, sts.range_ok, "divider launched for an out-of-range measurement")
  `PDFM_ASSERT_SAME(a_zero_when_bad, clk, rst, out_valid && !in_range, (high_ticks == '0) && (period_ticks == '0) && (duty_percent == '0) && (frequency_hz == '0), "out-of-range result has nonzero fields")
  `PDFM_ASSERT_SAME(a_duty_bound, clk, rst, out_valid && in_range, duty_percent < DUTY_SCALE, "duty of 100 percent or more")
  `PDFM_ASSERT_NEXT(a_load_sets_valid, clk, rst, cmd.load_out, out_valid, "loaded result not presented")

endmodule

`default_nettype wire

// ===== tb/pulse_duty_frequency_meter_tb.sv =====
// Self-checking testbench for pulse_duty_frequency_meter: streams pin levels,
// predicts each measurement in a scoreboard class and checks every result.
// Depends on pdfm_pkg and the pulse_duty_frequency_meter RTL.
`timescale 1ns / 1ps

module pulse_duty_frequency_meter_tb
  import pdfm_pkg::*;
();

  localparam int HOLD_OFF_CYCLES = 3000;
  localparam int SETTLE_CYCLES   = 80;
  localparam int PHASE_ITEMS     = 165;

  typedef enum logic [1:0] {
    PH_WAIT_RISE,
    PH_WAIT_FALL,
    PH_WAIT_CLOSE
  } meter_phase_e;

  typedef struct packed {
    bit              in_range;
    bit [FIELD_W-1:0] high;
    bit [FIELD_W-1:0] period;
    bit [DUTY_W-1:0]  duty;
    bit [RATE_W-1:0]  freq;
  } meter_result_t;

  class meter_scoreboard;
    bit [RATE_W-1:0]  rate;
    bit [FIELD_W-1:0] count;
    bit               prev_level;
    meter_phase_e     phase;
    bit [FIELD_W-1:0] t_rise;
    bit [FIELD_W-1:0] t_fall;
    meter_result_t    pending[$];
    int               errors;

    function void clear();
      rate       = RATE_RESET;
      count      = '0;
      prev_level = 1'b1;
      phase      = PH_WAIT_RISE;
      t_rise     = '0;
      t_fall     = '0;
      errors     = 0;
    endfunction

    function void set_rate(bit [RATE_W-1:0] v);
      rate = v;
    endfunction

    // Advance the measurement by one sampled level.
    function void note_request(bit lvl);
      bit            rising;
      bit            falling;
      meter_result_t r;
      bit [31:0]     hi;
      bit [31:0]     per;
      rising  = !prev_level && lvl;
      falling = prev_level && !lvl;
      case (phase)
        PH_WAIT_FALL: begin
          if (falling) begin
            t_fall = count;
            phase  = PH_WAIT_CLOSE;
          end
        end
        PH_WAIT_CLOSE: begin
          if (rising) begin
            r = '0;
            // Captures across a counter wrap do not strictly increase.
            if (t_rise < t_fall && t_fall < count) begin
              hi         = t_fall - t_rise;
              per        = count - t_rise;
              r.in_range = 1'b1;
              r.high     = hi[FIELD_W-1:0];
              r.period   = per[FIELD_W-1:0];
              r.duty     = (hi * 100) / per;
              r.freq     = rate / per;
            end
            pending.push_back(r);
            phase = PH_WAIT_RISE;
          end
        end
        default: begin
          if (rising) begin
            t_rise = count;
            phase  = PH_WAIT_FALL;
          end else begin
            phase = PH_WAIT_RISE;
          end
        end
      endcase
      prev_level = lvl;
      count++;
    endfunction

    function void cmp_field(string name, int unsigned e, int unsigned a);
      if (e != a) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(meter_result_t got);
      meter_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual high %0d period %0d",
                 $time, got.high, got.period);
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp_field("in_range", e.in_range, got.in_range);
      cmp_field("high_ticks", e.high, got.high);
      cmp_field("period_ticks", e.period, got.period);
      cmp_field("duty_percent", e.duty, got.duty);
      cmp_field("frequency_hz", e.freq, got.freq);
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [RATE_W-1:0]  cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic               pin_level;
  logic               out_valid;
  logic               out_ready;
  logic               in_range;
  logic [FIELD_W-1:0] high_ticks;
  logic [FIELD_W-1:0] period_ticks;
  logic [DUTY_W-1:0]  duty_percent;
  logic [RATE_W-1:0]  frequency_hz;

  meter_scoreboard board;
  int              results_seen;
  int              burst_left;
  bit              cur_level;

  pulse_duty_frequency_meter u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pin_level    (pin_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .in_range     (in_range),
    .high_ticks   (high_ticks),
    .period_ticks (period_ticks),
    .duty_percent (duty_percent),
    .frequency_hz (frequency_hz)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // One pin level per request; the sender works in bursts with idle gaps.
  task automatic send_level(input bit lvl);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 12);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    pin_level <= lvl;
    do @(posedge clk); while (!in_ready);
    board.note_request(lvl);
    burst_left--;
    cur_level = lvl;
  endtask

  task automatic send_run(input bit lvl, input int len);
    repeat (len) send_level(lvl);
  endtask

  // Mostly short runs so that measurements close often, now and then long ones.
  function automatic int pick_run_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 4);
    if (r < 95) return $urandom_range(5, 30);
    return $urandom_range(90, 250);
  endfunction

  // Quiet the input and let the divider finish before touching the register.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rate(input bit [RATE_W-1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_rate(v);
  endtask

  initial begin
    bit [RATE_W-1:0] rates[8];
    int              phase_items;
    int              len;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    pin_level  = 1'b1;
    burst_left = 0;
    cur_level  = 1'b1;
    board      = new();
    board.clear();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A falling edge while waiting for the opening edge is ignored; the closing
    // edge of one measurement never opens the next.
    send_level(1'b1);
    send_level(1'b0);
    send_level(1'b1);
    send_level(1'b0);
    send_level(1'b1);
    send_level(1'b1);
    send_level(1'b0);
    send_level(1'b1);
    send_run(1'b1, 2);
    send_level(1'b0);
    send_level(1'b1);
    send_level(1'b0);
    send_level(1'b1);
    send_level(1'b0);
    send_run(1'b0, 8);
    send_level(1'b1);

    rates[0] = RATE_RESET;
    rates[1] = 25'd1;
    rates[2] = 25'd20000000;
    rates[3] = '0;
    rates[4] = 25'h1FFFFFF;
    rates[5] = $urandom_range(1, 20000000);
    rates[6] = $urandom_range(0, 25'h1FFFFFF);
    rates[7] = RATE_RESET;
    for (int k = 0; k < 8; k++) begin
      if (k != 0) write_rate(rates[k]);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        len = pick_run_len();
        send_run(!cur_level, len);
        phase_items += len;
      end
    end

    wait_idle();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Receiver: its own ready pattern, plus one long hold-off so the block backs up.
  initial begin
    bit            ready_phase;
    bit            held;
    int            run_left;
    meter_result_t got;
    out_ready    = 1'b0;
    ready_phase  = 1'b0;
    held         = 1'b0;
    run_left     = 0;
    results_seen = 0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 5) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      if (run_left == 0) begin
        ready_phase = !ready_phase;
        if (ready_phase)
          run_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 16);
        else
          run_left = $urandom_range(1, 6);
      end
      run_left--;
      out_ready <= ready_phase;
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got.in_range = in_range;
        got.high     = high_ticks;
        got.period   = period_ticks;
        got.duty     = duty_percent;
        got.freq     = frequency_hz;
        board.check_result(got);
        results_seen++;
      end
    end
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/pdfm_pkg.sv
sv/pdfm_div.sv
sv/pdfm_dp.sv
sv/pdfm_ctrl.sv
sv/pulse_duty_frequency_meter.sv
tb/pulse_duty_frequency_meter_tb.sv
